>>> rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants, register codes and control types of the centered
// moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int MaxWindowDef    = 64;
  localparam int SampleBitsDef   = 16;
  localparam int FractionBitsDef = 8;

  // Configuration port geometry (fixed by the register map)
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;
  localparam int WinLenW  = 7;

  localparam logic [WinLenW-1:0] WinLenReset = 7'd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_ABSOLUTE_MODE = 1'b1
  } cfg_reg_e;

  // Sequencer to window store
  typedef struct packed {
    logic clear;   // restart the signal
    logic read;    // fetch the entry leaving the window
    logic update;  // write the new value, advance the sliding sum
  } win_ctrl_t;

endpackage

>>> rtl/cma_intf.sv
// ----------------------------------------------------------------------------
// cma channel interfaces
// Valid/ready channels for samples, averages and register writes.
// ----------------------------------------------------------------------------
interface cma_sample_if #(
  parameter int SAMPLE_BITS = cma_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface cma_average_if #(
  parameter int AVG_W = cma_pkg::SampleBitsDef + cma_pkg::FractionBitsDef + 1
);
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average;
  logic                    final_average;

  modport source (output valid, output average, output final_average, input ready);
  modport sink   (input valid, input average, input final_average, output ready);
endinterface

interface cma_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cma_pkg::CfgIdxW-1:0]  index;
  logic [cma_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/centered_moving_average_top.sv
// ----------------------------------------------------------------------------
// centered_moving_average_top
// Centered moving average over a sample stream, with end-of-signal flush.
// ----------------------------------------------------------------------------
//  channel    dir  payload                         beat taken when
//  sample_i   in   sample, final_sample            valid & ready
//  average_o  out  average, final_average          valid & ready
//  cfg_i      in   index (0 length, 1 abs), data   valid & ready (always ready)
//
//  A sample passes S_READ, S_UPDATE, S_CHECK and S_NEXT; one that yields an
//  average also passes S_DIVIDE and S_OUTPUT, waiting in S_DIVIDE on the serial
//  divider, which produces one quotient bit per cycle.
//  Each flushed zero runs the same states again from S_READ on.
//  No clearing pass after reset: the store is qualified by a fill count.
//  A stalled average holds the block; sample_i.ready stays low until done.
// ----------------------------------------------------------------------------
module centered_moving_average_top #(
  parameter int MAX_WINDOW    = cma_pkg::MaxWindowDef,
  parameter int SAMPLE_BITS   = cma_pkg::SampleBitsDef,
  parameter int FRACTION_BITS = cma_pkg::FractionBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cma_sample_if.sink    sample_i,
  cma_average_if.source average_o,
  cma_cfg_if.sink       cfg_i
);

  localparam int LenW   = $clog2(MAX_WINDOW + 1);
  localparam int StoreW = SAMPLE_BITS + 1;
  localparam int SumW   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int AVG_W  = SAMPLE_BITS + FRACTION_BITS + 1;
  localparam int CmpW   = (LenW > cma_pkg::WinLenW) ? LenW : cma_pkg::WinLenW;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_UPDATE = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_DIVIDE = 7'b0010000,
    S_OUTPUT = 7'b0100000,
    S_NEXT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [cma_pkg::WinLenW-1:0] wl_q, wl_d;
  logic                        abs_q, abs_d;
  logic signed [StoreW-1:0]    val_q, val_d;
  logic                        last_q, last_d;
  logic [LenW-1:0]             t_q, t_d;
  logic [LenW-1:0]             seen_q, seen_d;
  logic                        out_valid_q, out_valid_d;
  logic signed [AVG_W-1:0]     out_avg_q, out_avg_d;
  logic                        out_final_q, out_final_d;

  logic [LenW-1:0]          len;
  logic [LenW-1:0]          delay;
  logic                     in_beat, cfg_beat, out_beat;
  logic signed [StoreW-1:0] in_ext;
  logic                     emit;
  logic                     end_of_flush;
  logic                     div_start, div_done;
  logic signed [SumW-1:0]   sum;
  logic signed [AVG_W-1:0]  quot;
  cma_pkg::win_ctrl_t       win_ctrl;

  // Effective window length: zero acts as 1, oversize clamps to the store
  always_comb begin
    if (wl_q == '0) begin
      len = LenW'(1);
    end else if (CmpW'(wl_q) > CmpW'(MAX_WINDOW)) begin
      len = LenW'(MAX_WINDOW);
    end else begin
      len = LenW'(wl_q);
    end
  end

  assign delay = len - LenW'(1) - (len >> 1);

  assign in_beat  = sample_i.valid & sample_i.ready;
  assign cfg_beat = cfg_i.valid & cfg_i.ready;
  assign out_beat = average_o.valid & average_o.ready;

  assign in_ext = StoreW'(sample_i.sample);
  assign emit   = ((LenW + 1)'(seen_q) + (LenW + 1)'(t_q)) > (LenW + 1)'(delay);
  assign end_of_flush = last_q & (t_q == delay);

  always_comb begin
    state_d     = state_q;
    wl_d        = wl_q;
    abs_d       = abs_q;
    val_d       = val_q;
    last_d      = last_q;
    t_d         = t_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_avg_d   = out_avg_q;
    out_final_d = out_final_q;
    div_start   = 1'b0;
    win_ctrl    = '0;

    if (cfg_beat) begin
      case (cfg_i.index)
        cma_pkg::REG_WINDOW_LENGTH: wl_d  = cfg_i.data[cma_pkg::WinLenW-1:0];
        cma_pkg::REG_ABSOLUTE_MODE: abs_d = cfg_i.data[0];
        default: ;
      endcase
      win_ctrl.clear = 1'b1;
      seen_d         = '0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          val_d   = (abs_q && in_ext[StoreW-1]) ? -in_ext : in_ext;
          last_d  = sample_i.final_sample;
          t_d     = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        win_ctrl.read = 1'b1;
        state_d       = S_UPDATE;
      end
      S_UPDATE: begin
        win_ctrl.update = 1'b1;
        // only the real sample counts, not flush zeros
        if (t_q == '0 && seen_q != LenW'(MAX_WINDOW)) begin
          seen_d = seen_q + 1'b1;
        end
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (emit) begin
          div_start = 1'b1;
          state_d   = S_DIVIDE;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          out_avg_d   = quot;
          out_final_d = end_of_flush;
          out_valid_d = 1'b1;
          state_d     = S_OUTPUT;
        end
      end
      S_OUTPUT: begin
        if (out_beat) begin
          out_valid_d = 1'b0;
          state_d     = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (t_q == delay) begin
          win_ctrl.clear = 1'b1;
          seen_d         = '0;
          state_d        = S_IDLE;
        end else begin
          // push a zero to flush the next centered output
          t_d     = t_q + 1'b1;
          val_d   = '0;
          state_d = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= cma_pkg::WinLenReset;
      abs_q       <= 1'b0;
      last_q      <= 1'b0;
      t_q         <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wl_q        <= wl_d;
      abs_q       <= abs_d;
      last_q      <= last_d;
      t_q         <= t_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    out_avg_q   <= out_avg_d;
    out_final_q <= out_final_d;
  end

  cma_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .len_i  (len),
    .value_i(val_q),
    .sum_o  (sum)
  );

  cma_divider #(
    .SUM_W        (SumW),
    .LEN_W        (LenW),
    .FRACTION_BITS(FRACTION_BITS),
    .AVG_W        (AVG_W)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (sum),
    .len_i  (len),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign sample_i.ready          = (state_q == S_IDLE);
  assign cfg_i.ready             = 1'b1;
  assign average_o.valid         = out_valid_q;
  assign average_o.average       = out_avg_q;
  assign average_o.final_average = out_final_q;

endmodule

>>> rtl/cma_window.sv
// ----------------------------------------------------------------------------
// cma_window
// Circular sample store with a sliding sum over the last L entries.
// ----------------------------------------------------------------------------
module cma_window #(
  parameter int MAX_WINDOW  = cma_pkg::MaxWindowDef,
  parameter int SAMPLE_BITS = cma_pkg::SampleBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cma_pkg::win_ctrl_t        ctrl_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] len_i,
  input  logic signed [SAMPLE_BITS:0]     value_i,
  output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW):0] sum_o
);

  localparam int LenW   = $clog2(MAX_WINDOW + 1);
  localparam int AddrW  = $clog2(MAX_WINDOW);
  localparam int StoreW = SAMPLE_BITS + 1;
  localparam int SumW   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int PosW   = LenW + 1;

  logic signed [StoreW-1:0] mem [MAX_WINDOW];
  logic signed [StoreW-1:0] rd_q;
  logic signed [StoreW-1:0] old_val;

  logic [AddrW-1:0]       wp_q, wp_d;
  logic [LenW-1:0]        fill_q, fill_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [PosW-1:0]        pos_raw;
  logic [AddrW-1:0]       rd_addr;

  // Entry leaving the window sits L places behind the write position
  assign pos_raw = PosW'(wp_q) + PosW'(MAX_WINDOW) - PosW'(len_i);
  assign rd_addr = (pos_raw >= PosW'(MAX_WINDOW)) ? AddrW'(pos_raw - PosW'(MAX_WINDOW))
                                                  : AddrW'(pos_raw);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.read) begin
      rd_q <= mem[rd_addr];
    end
    if (ctrl_i.update) begin
      mem[wp_q] <= value_i;
    end
  end

  // Entries not yet written in this signal count as zero
  assign old_val = (fill_q >= len_i) ? rd_q : '0;

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (ctrl_i.clear) begin
      wp_d   = '0;
      fill_d = '0;
      sum_d  = '0;
    end else if (ctrl_i.update) begin
      sum_d = sum_q - SumW'(old_val) + SumW'(value_i);
      wp_d  = (wp_q == AddrW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
      if (fill_q != LenW'(MAX_WINDOW)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> rtl/cma_divider.sv
// ----------------------------------------------------------------------------
// cma_divider
// Serial restoring divider: (sum << FRACTION_BITS) / L, one quotient bit
// per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module cma_divider #(
  parameter int SUM_W         = 23,
  parameter int LEN_W         = 7,
  parameter int FRACTION_BITS = cma_pkg::FractionBitsDef,
  parameter int AVG_W         = 25
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic [LEN_W-1:0]        len_i,
  output logic                    done_o,
  output logic signed [AVG_W-1:0] quot_o
);

  localparam int DivW = SUM_W + FRACTION_BITS;
  localparam int CntW = $clog2(DivW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]  dvd_q, dvd_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             neg_q, neg_d;

  logic [SUM_W-1:0] mag;
  logic [LEN_W:0]   rem_sh;
  logic             fits;
  logic [DivW-1:0]  signed_q;

  assign mag    = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
  assign rem_sh = {rem_q, dvd_q[DivW-1]};
  assign fits   = rem_sh >= (LEN_W + 1)'(len_i);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = DivW'(mag) << FRACTION_BITS;
      rem_d  = '0;
      neg_d  = sum_i[SUM_W-1];
    end else if (busy_q) begin
      // Shift one dividend bit into the remainder, quotient bit enters at the bottom
      dvd_d = {dvd_q[DivW-2:0], fits};
      rem_d = fits ? LEN_W'(rem_sh - (LEN_W + 1)'(len_i)) : LEN_W'(rem_sh);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign signed_q = neg_q ? (~dvd_q + 1'b1) : dvd_q;
  assign quot_o   = AVG_W'(signed_q);
  assign done_o   = done_q;

endmodule

>>> rtl/cma_checker.sv
// ----------------------------------------------------------------------------
// cma_checker
// Port-level checks of the centered moving average block, bound to the top.
// ----------------------------------------------------------------------------
module cma_checker #(
  parameter int AVG_W = 25
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [AVG_W-1:0] out_average_i,
  input logic             out_final_i
);

  // One item at a time: no sample beat while an average is pending
  a_busy_while_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("sample channel ready while an average is pending");

  // A taken sample keeps the block busy on the next cycle
  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("sample channel ready right after a sample beat");

  // Nothing follows the last average of a signal without a new sample
  a_quiet_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_final_i) |=> !out_valid_i)
    else $error("average offered right after the final average");

  a_output_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_average_i) && $stable(out_final_i)))
    else $error("stalled average changed or dropped");

endmodule

bind centered_moving_average_top cma_checker #(
  .AVG_W(AVG_W)
) u_cma_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (average_o.valid),
  .out_ready_i  (average_o.ready),
  .out_average_i(average_o.average),
  .out_final_i  (average_o.final_average)
);
